### hw/rtl/dctd_pkg.sv
// ============================================================================
// dctd_pkg
// Shared widths, constants and controller/datapath interface types for the
// trial-division divisor counter.
// ============================================================================
`default_nettype none

package dctd_pkg;

    localparam int VALUE_BITS   = 40;
    localparam int TRIAL_BITS   = 21;
    localparam int SQ_BITS      = 2 * TRIAL_BITS;
    localparam int EXP_BITS     = 6;
    localparam int FACTOR_BITS  = EXP_BITS + 1;
    localparam int PROD_BITS    = 13;
    localparam int OUT_BITS     = 13;
    localparam int CNT_BITS     = $clog2(VALUE_BITS);

    localparam logic [TRIAL_BITS-1:0] MAX_TRIAL_DIVISOR = TRIAL_BITS'(1048576);
    localparam logic [PROD_BITS-1:0]  PRODUCT_MAX       = {PROD_BITS{1'b1}};
    localparam logic [CNT_BITS-1:0]   DIV_LAST          = CNT_BITS'(VALUE_BITS - 1);

    typedef struct packed {
        logic load;
        logic square;
        logic div_start;
        logic div_step;
        logic accept_factor;
        logic next_div;
        logic final_scale;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic sq_le_rem;
        logic div_done;
        logic rem_zero;
        logic rem_gt_one;
    } t_dp_sts;

endpackage

`default_nettype wire

### hw/rtl/dctd_datapath.sv
// ============================================================================
// dctd_datapath
// Remaining value, trial divisor, its square, a bit-serial restoring
// divider, exponent and saturating product, and the output word register.
// ============================================================================
`default_nettype none

module dctd_datapath (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  dctd_pkg::t_dp_cmd                 i_cmd,
    input  wire  [dctd_pkg::VALUE_BITS-1:0]   i_value,
    output dctd_pkg::t_dp_sts                 o_sts,
    output logic [dctd_pkg::OUT_BITS-1:0]     o_bases_with_zero
);

    logic [dctd_pkg::VALUE_BITS-1:0]  r_rem, n_rem;
    logic [dctd_pkg::TRIAL_BITS-1:0]  r_t, n_t;
    logic [dctd_pkg::SQ_BITS-1:0]     r_sq, n_sq;
    logic [dctd_pkg::VALUE_BITS-1:0]  r_quo, n_quo;
    logic [dctd_pkg::TRIAL_BITS-1:0]  r_part, n_part;
    logic [dctd_pkg::CNT_BITS-1:0]    r_cnt, n_cnt;
    logic [dctd_pkg::EXP_BITS-1:0]    r_exp, n_exp;
    logic [dctd_pkg::PROD_BITS-1:0]   r_prod, n_prod;
    logic [dctd_pkg::OUT_BITS-1:0]    r_out, n_out;

    logic [dctd_pkg::TRIAL_BITS:0]    shifted;
    logic [dctd_pkg::TRIAL_BITS:0]    diff;
    logic                             ge;
    logic [dctd_pkg::FACTOR_BITS-1:0] factor;
    logic [dctd_pkg::PROD_BITS+dctd_pkg::FACTOR_BITS-1:0] prod_full;
    logic [dctd_pkg::PROD_BITS-1:0]   prod_sat;

    always_comb begin
        shifted = {r_part, r_quo[dctd_pkg::VALUE_BITS-1]};
        diff    = shifted - {1'b0, r_t};
        ge      = (shifted >= {1'b0, r_t});

        factor = i_cmd.final_scale ? dctd_pkg::FACTOR_BITS'(2)
                                   : ({1'b0, r_exp} + dctd_pkg::FACTOR_BITS'(1));
        prod_full = {{dctd_pkg::FACTOR_BITS{1'b0}}, r_prod}
                  * {{dctd_pkg::PROD_BITS{1'b0}}, factor};
        prod_sat  = (prod_full > {{dctd_pkg::FACTOR_BITS{1'b0}}, dctd_pkg::PRODUCT_MAX})
                  ? dctd_pkg::PRODUCT_MAX : prod_full[dctd_pkg::PROD_BITS-1:0];
    end

    always_comb begin
        n_rem  = r_rem;
        n_t    = r_t;
        n_sq   = r_sq;
        n_quo  = r_quo;
        n_part = r_part;
        n_cnt  = r_cnt;
        n_exp  = r_exp;
        n_prod = r_prod;
        n_out  = r_out;
        if (i_cmd.load) begin
            n_rem  = i_value;
            n_t    = dctd_pkg::TRIAL_BITS'(2);
            n_exp  = '0;
            n_prod = dctd_pkg::PROD_BITS'(1);
        end
        if (i_cmd.square) begin
            n_sq = {{dctd_pkg::TRIAL_BITS{1'b0}}, r_t} * {{dctd_pkg::TRIAL_BITS{1'b0}}, r_t};
        end
        if (i_cmd.div_start) begin
            n_quo  = r_rem;
            n_part = '0;
            n_cnt  = '0;
        end
        if (i_cmd.div_step) begin
            n_part = ge ? diff[dctd_pkg::TRIAL_BITS-1:0]
                        : shifted[dctd_pkg::TRIAL_BITS-1:0];
            n_quo  = {r_quo[dctd_pkg::VALUE_BITS-2:0], ge};
            n_cnt  = r_cnt + dctd_pkg::CNT_BITS'(1);
        end
        if (i_cmd.accept_factor) begin
            n_rem  = r_quo;
            n_exp  = r_exp + dctd_pkg::EXP_BITS'(1);
            n_part = '0;
            n_cnt  = '0;
        end
        if (i_cmd.next_div) begin
            n_prod = prod_sat;
            n_exp  = '0;
            n_t    = (r_t == dctd_pkg::TRIAL_BITS'(2)) ? dctd_pkg::TRIAL_BITS'(3)
                                                      : r_t + dctd_pkg::TRIAL_BITS'(2);
        end
        if (i_cmd.final_scale) begin
            n_prod = prod_sat;
        end
        if (i_cmd.load_out) begin
            n_out = r_prod - dctd_pkg::OUT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_t    <= n_t;
        r_sq   <= n_sq;
        r_quo  <= n_quo;
        r_part <= n_part;
        r_cnt  <= n_cnt;
        r_exp  <= n_exp;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    always_comb begin
        o_sts.sq_le_rem  = (r_t <= dctd_pkg::MAX_TRIAL_DIVISOR)
                        && (r_sq <= {{(dctd_pkg::SQ_BITS-dctd_pkg::VALUE_BITS){1'b0}}, r_rem});
        o_sts.div_done   = (r_cnt == dctd_pkg::DIV_LAST);
        o_sts.rem_zero   = (r_part == '0);
        o_sts.rem_gt_one = (r_rem > dctd_pkg::VALUE_BITS'(1));
    end

    assign o_bases_with_zero = r_out;

    a_part_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |=> (r_part < r_t))
        else $error("partial remainder not below trial divisor");

    a_prod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.next_div || i_cmd.final_scale) |=> (r_prod != '0))
        else $error("divisor product collapsed to zero");

endmodule

`default_nettype wire

### hw/rtl/dctd_ctrl.sv
// ============================================================================
// dctd_ctrl
// Sequencer for trial division: square check, serial divide, factor test,
// final scaling and output word handoff.
// ============================================================================
`default_nettype none

module dctd_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    input  dctd_pkg::t_dp_sts   i_sts,
    output dctd_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SQUARE = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_TEST   = 3'd4;
    localparam logic [2:0] S_FINAL  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.sq_le_rem) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_sts.rem_zero) begin
                    o_cmd.accept_factor = 1'b1;
                    n_state             = S_DIV;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_SQUARE;
                end
            end
            S_FINAL: begin
                o_cmd.final_scale = i_sts.rem_gt_one;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_SQUARE))
        else $error("accepted word did not start factoring");

    a_factor_only_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept_factor |-> (r_state == S_TEST) && i_sts.rem_zero)
        else $error("factor taken with nonzero remainder");

    a_div_ends_in_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_sts.div_done |=> (r_state == S_TEST))
        else $error("divide did not finish into test");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("pending output word overwritten");

endmodule

`default_nettype wire

### hw/rtl/divisor_count_trial_division.sv
// ============================================================================
// divisor_count_trial_division
// Counts the divisors of a 40-bit value, minus one, by trial division with
// 2 and every odd candidate while the candidate squared fits the remainder.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | i_in_valid, o_in_stall, i_value         | to block
//   out     | o_out_valid, i_out_stall, o_bases_with_zero | from block
//
// Each trial divisor runs square, check, a bit-serial restoring divide and
// test; every factor found adds another divide and test, and the word
// finishes with final scaling and the output handoff, then returns to idle
// before the next word is taken.
// Synchronous active-low reset returns to idle with no output word pending.
// The output register lets a new word enter while a result waits; a stalled
// output holds the block only at the point of handing off the next result.
// ============================================================================
`default_nettype none

module divisor_count_trial_division (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [dctd_pkg::VALUE_BITS-1:0]  i_value,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [dctd_pkg::OUT_BITS-1:0]    o_bases_with_zero
);

    dctd_pkg::t_dp_cmd cmd;
    dctd_pkg::t_dp_sts sts;

    dctd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    dctd_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_value           (i_value),
        .o_sts             (sts),
        .o_bases_with_zero (o_bases_with_zero)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for divisor_count_trial_division. A directed table covers
// zero, one, small primes and squares, powers of two, three and five, the
// all-ones value and the 40-bit value with the most divisors. Random words
// follow: products of small primes, small primes times a larger odd cofactor,
// small values and values with random upper bits. Every result is compared
// with a trial-division predictor or with a count typed into the table. Both
// channels idle and stall at random.
// ============================================================================
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TRIAL_LIMIT = 64'd1048576;
    localparam int unsigned     PRODUCT_CAP = 8191;
    localparam longint unsigned VALUE_TOP   = (64'd1 << dctd_pkg::VALUE_BITS) - 1;
    localparam int              N_DIRECTED  = 17;
    localparam int              N_RANDOM    = 100;
    localparam int              DRAIN_CYCLES = 100;
    localparam int              N_PRIMES    = 25;

    typedef struct packed {
        logic [dctd_pkg::VALUE_BITS-1:0] value;
        logic [dctd_pkg::OUT_BITS-1:0]   count;
    } t_count_job;

    typedef struct packed {
        logic [dctd_pkg::VALUE_BITS-1:0] value;
        logic                            known;
        logic [dctd_pkg::OUT_BITS-1:0]   count;
    } t_trial_row;

    localparam int SMALL_PRIMES [N_PRIMES] = '{
        2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
        43, 47, 53, 59, 61, 67, 71, 73, 79, 83, 89, 97
    };

    localparam t_trial_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{40'd0,             1'b1, 13'd0},
        '{40'd1,             1'b1, 13'd0},
        '{40'd2,             1'b1, 13'd1},
        '{40'd3,             1'b1, 13'd1},
        '{40'd4,             1'b1, 13'd2},
        '{40'd6,             1'b0, 13'd0},
        '{40'd36,            1'b0, 13'd0},
        '{40'd97,            1'b0, 13'd0},
        '{40'd121,           1'b0, 13'd0},
        '{40'd1000001,       1'b0, 13'd0},
        '{40'd65521,         1'b0, 13'd0},
        '{40'd720720,        1'b0, 13'd0},
        '{40'd549755813888,  1'b1, 13'd39},
        '{40'hFF_FFFF_FFFF,  1'b1, 13'd191},
        '{40'd963761198400,  1'b1, 13'd6719},
        '{40'd847288609443,  1'b1, 13'd25},
        '{40'd762939453125,  1'b1, 13'd17}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [dctd_pkg::VALUE_BITS-1:0] i_value = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [dctd_pkg::OUT_BITS-1:0]   o_bases_with_zero;

    t_count_job pending_counts [$];
    int unsigned error_count = 0;

    divisor_count_trial_division dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_bases_with_zero (o_bases_with_zero)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [dctd_pkg::OUT_BITS-1:0] count_bases(
        input logic [dctd_pkg::VALUE_BITS-1:0] value);
        longint unsigned rest;
        longint unsigned trial;
        int unsigned     power;
        int unsigned     prod;
        rest  = value;
        trial = 2;
        prod  = 1;
        while (trial <= TRIAL_LIMIT && rest != 0 && trial <= rest / trial) begin
            power = 0;
            while (rest % trial == 0) begin
                rest  = rest / trial;
                power = (power + 1) & 32'h3F;
            end
            prod  = (prod * (power + 1) > PRODUCT_CAP) ? PRODUCT_CAP : prod * (power + 1);
            trial = (trial == 2) ? 3 : trial + 2;
        end
        if (rest > 1) begin
            prod = (prod * 2 > PRODUCT_CAP) ? PRODUCT_CAP : prod * 2;
        end
        return dctd_pkg::OUT_BITS'(prod - 1);
    endfunction

    function automatic int unsigned pick_gap(input int unsigned long_max);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, long_max);
    endfunction

    function automatic logic [dctd_pkg::VALUE_BITS-1:0] draw_value();
        longint unsigned v;
        longint unsigned p;
        int unsigned     kind;
        int unsigned     picks;
        kind = $urandom_range(0, 99);
        v    = 1;
        if (kind < 25) begin
            return dctd_pkg::VALUE_BITS'($urandom_range(0, 65535));
        end else if (kind < 37) begin
            return {20'($urandom_range(0, 1048575)), 20'd0};
        end
        picks = $urandom_range(1, 14);
        repeat (picks) begin
            p = SMALL_PRIMES[$urandom_range(0, N_PRIMES - 1)];
            if (v * p <= VALUE_TOP) begin
                v = v * p;
            end
        end
        if (kind < 60) begin
            p = $urandom_range(1, 65535) * 2 + 1;
            if (v * p <= VALUE_TOP) begin
                v = v * p;
            end
        end
        if ($urandom_range(0, 1) == 1) begin
            p = 64'd1 << $urandom_range(0, dctd_pkg::VALUE_BITS - 1);
            if (v <= VALUE_TOP / p) begin
                v = v * p;
            end
        end
        return dctd_pkg::VALUE_BITS'(v);
    endfunction

    task automatic send_value(input logic [dctd_pkg::VALUE_BITS-1:0] value,
                              input logic [dctd_pkg::OUT_BITS-1:0] count);
        t_count_job job;
        job.value  = value;
        job.count  = count;
        i_in_valid <= 1'b1;
        i_value    <= value;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_counts = {pending_counts, job};
    endtask

    task automatic wait_drained();
        while (pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic idle_input(input bit drain);
        int unsigned gap;
        gap = pick_gap(60);
        if (drain) begin
            i_in_valid <= 1'b0;
            wait_drained();
        end else if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_count_job job;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_counts.size() == 0) begin
                $error("bases_with_zero: expected none, actual %0d", o_bases_with_zero);
                error_count++;
            end else begin
                job = pending_counts.pop_front();
                if (o_bases_with_zero !== job.count) begin
                    $error("bases_with_zero: expected %0d, actual %0d (value %0d)",
                           job.count, o_bases_with_zero, job.value);
                    error_count++;
                end
            end
        end
    end

    initial begin : out_stall_gen
        int unsigned free_run;
        int unsigned hold;
        @(posedge i_clk);
        forever begin
            free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 3000)
                                                   : $urandom_range(1, 8);
            i_out_stall <= 1'b0;
            repeat (free_run) @(posedge i_clk);
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                               : $urandom_range(1, 3);
            i_out_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
        end
    end

    initial begin : run_limit
        #64_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [dctd_pkg::VALUE_BITS-1:0] value;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            value = DIRECTED_ROWS[i].value;
            send_value(value, DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].count
                                                     : count_bases(value));
            idle_input(i == N_DIRECTED - 1);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            value = draw_value();
            send_value(value, count_bases(value));
            idle_input(i == N_RANDOM - 1 || $urandom_range(0, 11) == 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_counts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
